// ===== design/tps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

  localparam int WORD = 32;

  typedef struct packed {
    logic signed [WORD-1:0] vert_x;
    logic signed [WORD-1:0] vert_y;
    logic signed [WORD-1:0] vert_z;
  } vertex_t;

  typedef struct packed {
    logic signed [WORD-1:0] proj_x;
    logic signed [WORD-1:0] proj_y;
    logic signed [WORD-1:0] proj_depth;
    logic signed [WORD-1:0] inverse_det;
    logic signed [WORD-1:0] box_min_x;
    logic signed [WORD-1:0] box_min_y;
    logic signed [WORD-1:0] box_max_x;
    logic signed [WORD-1:0] box_max_y;
    logic                   triangle_done;
    logic                   divide_fault;
  } result_t;

  localparam logic [WORD-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD-1:0] SAT_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== design/tps_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial signed multiplier, one multiplier bit per cycle, with the
// fixed-point product taken by a floor shift.
module tps_mul #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      p
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] hi;
  logic [31:0] lo;
  logic [31:0] mcand;
  logic [33:0] ma;
  logic [33:0] addend;
  logic [33:0] t;
  logic [63:0] prod;

  always_comb begin
    ma = {{2{mcand[31]}}, mcand};
    if (lo[0]) begin
      addend = (cnt == 6'd31) ? (~ma + 34'd1) : ma;
    end else begin
      addend = '0;
    end
    t    = {hi[32], hi} + addend;
    prod = {hi[31:0], lo};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      if (cnt == 6'd32) begin
        busy <= 1'b0;
        done <= 1'b1;
        p    <= prod[FRACTION_BITS+31:FRACTION_BITS];
      end else begin
        hi  <= t[33:1];
        lo  <= {t[0], lo[31:1]};
        cnt <= cnt + 6'd1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/tps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle: (n << FRACTION_BITS) / d,
// truncated toward zero, saturating with a fault flag.
module tps_div #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] n,
  input  wire logic [31:0] d,
  output logic             done,
  output logic [31:0]      q,
  output logic             fault
);

  localparam int NB = 32 + FRACTION_BITS;
  localparam int CW = $clog2(NB + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [31:0]   rem;
  logic [NB-1:0] dvd;
  logic [NB-1:0] quo;
  logic [31:0]   ud;
  logic          neg;
  logic [31:0]   abs_n;
  logic [31:0]   abs_d;
  logic [32:0]   rs;
  logic [32:0]   rdiff;
  logic          ge;
  logic          sat_pos;
  logic          sat_neg;

  always_comb begin
    abs_n   = n[31] ? (~n + 32'd1) : n;
    abs_d   = d[31] ? (~d + 32'd1) : d;
    rs      = {rem, dvd[NB-1]};
    rdiff   = rs - {1'b0, ud};
    ge      = !rdiff[32];
    sat_pos = |quo[NB-1:31];
    sat_neg = (|quo[NB-1:32]) | (quo[31] & (|quo[30:0]));
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      if (d == '0) begin
        done  <= 1'b1;
        fault <= 1'b1;
        q     <= n[31] ? tps_pkg::SAT_MIN : tps_pkg::SAT_MAX;
      end else begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= {abs_n, {FRACTION_BITS{1'b0}}};
        quo  <= '0;
        ud   <= abs_d;
        neg  <= n[31] ^ d[31];
      end
    end else if (busy) begin
      if (cnt == CW'(NB)) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (!neg) begin
          q     <= sat_pos ? tps_pkg::SAT_MAX : quo[31:0];
          fault <= sat_pos;
        end else begin
          q     <= sat_neg ? tps_pkg::SAT_MIN : (~quo[31:0] + 32'd1);
          fault <= sat_neg;
        end
      end else begin
        rem <= ge ? rdiff[31:0] : rs[31:0];
        quo <= {quo[NB-2:0], ge};
        dvd <= {dvd[NB-2:0], 1'b0};
        cnt <= cnt + CW'(1);
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/triangle_projection_setup.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Triangle setup with perspective projection. A vertex item is taken when
// start is high and busy is low; its result appears on result for exactly
// one cycle with result_valid high, and the receiver cannot stall it, so
// it must take every result in that cycle. One item at a time is worked
// on: a vertex costs twelve bit-serial multiplies, three serial divides
// when w is not exactly one (each skips the serial loop and faults when w
// is zero), and on the third vertex of a triangle two more multiplies and
// one more divide, before the result is registered and presented.
// busy drops in the cycle of the result strobe, so the next item can be
// taken at the edge that takes the result. The shared serial multiplier
// and divider set the time that a vertex takes.
// The matrix is written over the APB port only while busy is low: this
// binds the user, and the block itself does not enforce it.
module triangle_projection_setup #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire tps_pkg::vertex_t vert,
  output logic                  busy,
  output tps_pkg::result_t      result,
  output logic                  result_valid,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [5:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam logic [31:0] ONE = 32'd1 << FRACTION_BITS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROJ = 6'b000010,
    S_DIV  = 6'b000100,
    S_DET  = 6'b001000,
    S_INV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [63:0] mat [8];
  logic [31:0] vin [3];
  logic [31:0] colv [4];
  logic [31:0] acc;
  logic [31:0] det;
  logic [31:0] inv;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [1:0]  k;
  logic [1:0]  slot;
  logic        fault;
  logic [31:0] held_x [2];
  logic [31:0] held_y [2];
  logic        mul_go;
  logic        div_go;

  logic        mul_done;
  logic [31:0] mul_p;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic        div_done;
  logic [31:0] div_q;
  logic        div_fault;
  logic [31:0] div_n;
  logic [31:0] div_d;
  logic [31:0] acc_sum;
  logic [31:0] col_sum;
  logic [31:0] min_x;
  logic [31:0] min_y;
  logic [31:0] max_x;
  logic [31:0] max_y;

  function automatic logic [31:0] mat_entry(input logic [63:0] m [8],
                                            input logic [1:0] r,
                                            input logic [1:0] c);
    logic [63:0] reg_val;
    reg_val = m[{r, c[1]}];
    return c[0] ? reg_val[63:32] : reg_val[31:0];
  endfunction

  function automatic logic [31:0] smin(input logic [31:0] x, input logic [31:0] y);
    return ($signed(x) > $signed(y)) ? y : x;
  endfunction

  function automatic logic [31:0] smax(input logic [31:0] x, input logic [31:0] y);
    return ($signed(x) < $signed(y)) ? y : x;
  endfunction

  // The configuration port always completes in its access cycle.
  assign pready = 1'b1;
  assign prdata = mat[paddr[5:3]];
  assign busy   = (state != S_IDLE);

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    if (state == S_DET) begin
      mul_a = (k == 2'd0) ? (held_x[1] - held_x[0]) : (colv[0] - held_x[0]);
      mul_b = (k == 2'd0) ? (colv[1] - held_y[0]) : (held_y[1] - held_y[0]);
    end else begin
      mul_a = mat_entry(mat, row, col);
      mul_b = vin[row];
    end
    if (state == S_INV) begin
      div_n = ONE;
      div_d = det;
    end else begin
      div_n = colv[k];
      div_d = colv[3];
    end
    acc_sum = acc + mul_p;
    col_sum = acc_sum + mat_entry(mat, 2'd3, col);
    min_x = smin(smin(held_x[0], held_x[1]), colv[0]);
    min_y = smin(smin(held_y[0], held_y[1]), colv[1]);
    max_x = smax(smax(held_x[0], held_x[1]), colv[0]);
    max_y = smax(smax(held_y[0], held_y[1]), colv[1]);
  end

  tps_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  tps_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q),
    .fault (div_fault)
  );

  // Configuration writes land on the access cycle of an APB write.
  always_ff @(posedge clk) begin
    if (psel && penable && pwrite && pready) begin
      mat[paddr[5:3]] <= pwdata;
    end
    if (rst) begin
      mat[0] <= 64'h0000_0000_0001_0000;
      mat[1] <= 64'h0;
      mat[2] <= 64'h0001_0000_0000_0000;
      mat[3] <= 64'h0;
      mat[4] <= 64'h0;
      mat[5] <= 64'h0000_0000_0001_0000;
      mat[6] <= 64'h0;
      mat[7] <= 64'h0001_0000_0000_0000;
    end
  end

  // Sequencer: each column is three multiply-accumulate passes plus the
  // translation term, then the optional divide by w, then the edge
  // determinant and its inverse on the closing vertex of a triangle.
  always_ff @(posedge clk) begin
    mul_go       <= 1'b0;
    div_go       <= 1'b0;
    result_valid <= 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          vin[0] <= vert.vert_x;
          vin[1] <= vert.vert_y;
          vin[2] <= vert.vert_z;
          acc    <= '0;
          row    <= '0;
          col    <= '0;
          fault  <= 1'b0;
          mul_go <= 1'b1;
          state  <= S_PROJ;
        end
      end
      S_PROJ: begin
        if (mul_done) begin
          if (row == 2'd2) begin
            colv[col] <= col_sum;
            acc       <= '0;
            row       <= '0;
            if (col == 2'd3) begin
              k <= '0;
              if (col_sum != ONE) begin
                div_go <= 1'b1;
                state  <= S_DIV;
              end else if (slot == 2'd2) begin
                mul_go <= 1'b1;
                state  <= S_DET;
              end else begin
                state <= S_OUT;
              end
            end else begin
              col    <= col + 2'd1;
              mul_go <= 1'b1;
            end
          end else begin
            acc    <= acc_sum;
            row    <= row + 2'd1;
            mul_go <= 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          colv[k] <= div_q;
          fault   <= fault | div_fault;
          if (k == 2'd2) begin
            k <= '0;
            if (slot == 2'd2) begin
              mul_go <= 1'b1;
              state  <= S_DET;
            end else begin
              state <= S_OUT;
            end
          end else begin
            k      <= k + 2'd1;
            div_go <= 1'b1;
          end
        end
      end
      S_DET: begin
        if (mul_done) begin
          if (k == 2'd0) begin
            det    <= mul_p;
            k      <= 2'd1;
            mul_go <= 1'b1;
          end else begin
            det    <= det - mul_p;
            div_go <= 1'b1;
            state  <= S_INV;
          end
        end
      end
      S_INV: begin
        if (div_done) begin
          inv   <= div_q;
          fault <= fault | div_fault;
          state <= S_OUT;
        end
      end
      S_OUT: begin
        result_valid         <= 1'b1;
        result.proj_x        <= colv[0];
        result.proj_y        <= colv[1];
        result.proj_depth    <= colv[2];
        result.divide_fault  <= fault;
        if (slot == 2'd2) begin
          result.inverse_det   <= inv;
          result.box_min_x     <= min_x;
          result.box_min_y     <= min_y;
          result.box_max_x     <= max_x;
          result.box_max_y     <= max_y;
          result.triangle_done <= 1'b1;
          slot                 <= '0;
        end else begin
          result.inverse_det   <= '0;
          result.box_min_x     <= '0;
          result.box_min_y     <= '0;
          result.box_max_x     <= '0;
          result.box_max_y     <= '0;
          result.triangle_done <= 1'b0;
          held_x[slot[0]]      <= colv[0];
          held_y[slot[0]]      <= colv[1];
          slot                 <= slot + 2'd1;
        end
        state <= S_IDLE;
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state        <= S_IDLE;
      slot         <= '0;
      mul_go       <= 1'b0;
      div_go       <= 1'b0;
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_triangle_projection_setup.sv =====
`timescale 1ns / 1ps

module tb_triangle_projection_setup;

  localparam int FRAC = 16;
  localparam int NUM_RANDOM = 1300;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [31:0] FX_ONE = 32'sd1 << FRAC;

  logic clk;
  logic rst;
  logic start;
  tps_pkg::vertex_t vert;
  logic busy;
  tps_pkg::result_t result;
  logic result_valid;
  logic psel, penable, pwrite;
  logic [5:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  int error_count;
  int idle_cycles;
  int triangles_seen;
  int faults_seen;

  triangle_projection_setup #(.FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .vert(vert), .busy(busy),
    .result(result), .result_valid(result_valid), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // The clock runs with a 20 ns period for the whole simulation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every mismatch goes through this task so the count stays in one place.
  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // The projection scoreboard keeps its own copy of the matrix and of the
  // two held screen positions, and queues one projected vertex per item.
  class projection_board;
    logic [63:0] matrix_regs [8];
    int unsigned slot;
    logic signed [31:0] held_x [2];
    logic signed [31:0] held_y [2];
    tps_pkg::result_t projected_q [$];

    function new();
      matrix_regs[0] = 64'd65536;
      matrix_regs[1] = 64'd0;
      matrix_regs[2] = 64'd65536 << 32;
      matrix_regs[3] = 64'd0;
      matrix_regs[4] = 64'd0;
      matrix_regs[5] = 64'd65536;
      matrix_regs[6] = 64'd0;
      matrix_regs[7] = 64'd65536 << 32;
      slot = 0;
    endfunction

    function logic signed [31:0] fx_mul(logic signed [31:0] a,
                                        logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return 32'(p >>> FRAC);
    endfunction

    // Truncating divide toward zero with saturation; a zero divisor
    // saturates by the sign of the numerator.
    function logic signed [31:0] fx_div(logic signed [31:0] n,
                                        logic signed [31:0] d,
                                        inout logic fault);
      logic [63:0] un, ud, q;
      logic neg;
      if (d == 0) begin
        fault = 1'b1;
        return n < 0 ? $signed(tps_pkg::SAT_MIN) : $signed(tps_pkg::SAT_MAX);
      end
      un = n < 0 ? 64'(-64'(n)) : 64'(n);
      un = un << FRAC;
      ud = d < 0 ? 64'(-64'(d)) : 64'(d);
      q = un / ud;
      neg = (n < 0) != (d < 0);
      if (!neg) begin
        if (q > 64'h7FFF_FFFF) begin
          fault = 1'b1;
          return $signed(tps_pkg::SAT_MAX);
        end
        return $signed(q[31:0]);
      end
      if (q > 64'h8000_0000) begin
        fault = 1'b1;
        return $signed(tps_pkg::SAT_MIN);
      end
      return $signed(32'(64'd0 - q));
    endfunction

    function logic signed [31:0] entry(int r, int c);
      logic [63:0] reg_val;
      reg_val = matrix_regs[(r << 1) | (c >> 1)];
      return (c & 1) ? $signed(reg_val[63:32]) : $signed(reg_val[31:0]);
    endfunction

    function logic signed [31:0] column(int c, tps_pkg::vertex_t v);
      logic signed [31:0] s;
      s = fx_mul(entry(0, c), v.vert_x);
      s = s + fx_mul(entry(1, c), v.vert_y);
      s = s + fx_mul(entry(2, c), v.vert_z);
      return s + entry(3, c);
    endfunction

    function automatic logic signed [31:0] smin(logic signed [31:0] a,
                                                logic signed [31:0] b);
      return a > b ? b : a;
    endfunction

    function automatic logic signed [31:0] smax(logic signed [31:0] a,
                                                logic signed [31:0] b);
      return a < b ? b : a;
    endfunction

    function void note_vertex(tps_pkg::vertex_t v);
      tps_pkg::result_t r;
      logic signed [31:0] w, ex1, ex2, ey1, ey2, det;
      logic fault;
      r = '0;
      fault = 1'b0;
      r.proj_x = column(0, v);
      r.proj_y = column(1, v);
      r.proj_depth = column(2, v);
      w = column(3, v);
      if (w != FX_ONE) begin
        r.proj_x = fx_div(r.proj_x, w, fault);
        r.proj_y = fx_div(r.proj_y, w, fault);
        r.proj_depth = fx_div(r.proj_depth, w, fault);
      end
      if (slot < 2) begin
        held_x[slot] = r.proj_x;
        held_y[slot] = r.proj_y;
        slot++;
      end else begin
        ex1 = held_x[1] - held_x[0];
        ex2 = r.proj_x - held_x[0];
        ey1 = held_y[1] - held_y[0];
        ey2 = r.proj_y - held_y[0];
        det = fx_mul(ex1, ey2) - fx_mul(ex2, ey1);
        r.inverse_det = fx_div(FX_ONE, det, fault);
        r.box_min_x = smin(smin(held_x[0], held_x[1]), r.proj_x);
        r.box_min_y = smin(smin(held_y[0], held_y[1]), r.proj_y);
        r.box_max_x = smax(smax(held_x[0], held_x[1]), r.proj_x);
        r.box_max_y = smax(smax(held_y[0], held_y[1]), r.proj_y);
        r.triangle_done = 1'b1;
        slot = 0;
      end
      r.divide_fault = fault;
      projected_q.push_back(r);
    endfunction

    // Compares one strobed result against the oldest projected vertex.
    task check_result(tps_pkg::result_t got);
      tps_pkg::result_t want;
      if (projected_q.size() == 0) begin
        report("unexpected result", 32'd0, 32'd0);
        return;
      end
      want = projected_q.pop_front();
      if (got.proj_x !== want.proj_x) report("proj_x", got.proj_x, want.proj_x);
      if (got.proj_y !== want.proj_y) report("proj_y", got.proj_y, want.proj_y);
      if (got.proj_depth !== want.proj_depth)
        report("proj_depth", got.proj_depth, want.proj_depth);
      if (got.inverse_det !== want.inverse_det)
        report("inverse_det", got.inverse_det, want.inverse_det);
      if (got.box_min_x !== want.box_min_x)
        report("box_min_x", got.box_min_x, want.box_min_x);
      if (got.box_min_y !== want.box_min_y)
        report("box_min_y", got.box_min_y, want.box_min_y);
      if (got.box_max_x !== want.box_max_x)
        report("box_max_x", got.box_max_x, want.box_max_x);
      if (got.box_max_y !== want.box_max_y)
        report("box_max_y", got.box_max_y, want.box_max_y);
      if (got.triangle_done !== want.triangle_done)
        report("triangle_done", 32'(got.triangle_done), 32'(want.triangle_done));
      if (got.divide_fault !== want.divide_fault)
        report("divide_fault", 32'(got.divide_fault), 32'(want.divide_fault));
    endtask
  endclass

  projection_board board;

  // Results cannot be stalled, so every strobe is checked at the edge that
  // ends its cycle. Any accepted item or result resets the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        if (result.triangle_done) triangles_seen++;
        if (result.divide_fault) faults_seen++;
        board.check_result(result);
      end
      if (result_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_triangle_projection_setup: done, errors");
        $finish;
      end
    end
  end

  // APB write with a setup and an access phase; the model copy is updated at
  // the access edge. The port then idles before the next transfer.
  task automatic write_matrix(input int index, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(index * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.matrix_regs[index] = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for the scoreboard to drain, then allows the block's worst-case
  // vertex time so no item is still in flight before touching registers.
  task automatic wait_drained();
    while (board.projected_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  // Waits until the block is free, then presents one vertex after a random
  // gap when gaps is set and holds start until the block has taken it and is free again.
  task automatic send_vertex(input tps_pkg::vertex_t v, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    while (busy) @(posedge clk);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    vert <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_vertex(v);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 8 << FRAC)) - (32'sd4 << FRAC));
      2: return $signed(tps_pkg::SAT_MAX);
      3: return $signed(tps_pkg::SAT_MIN);
      default: return 32'sd0;
    endcase
  endfunction

  function automatic tps_pkg::vertex_t make_vertex(int mode);
    tps_pkg::vertex_t v;
    v.vert_x = pick_coord(mode);
    v.vert_y = pick_coord(mode);
    v.vert_z = pick_coord(mode);
    return v;
  endfunction

  // Matrix entries are either small fixed-point values or raw random bits.
  function automatic logic [63:0] random_pair(bit wild);
    logic [31:0] lo, hi;
    if (wild) begin
      lo = $urandom();
      hi = $urandom();
    end else begin
      lo = 32'($urandom_range(0, 4 << FRAC)) - (32'd2 << FRAC);
      hi = 32'($urandom_range(0, 4 << FRAC)) - (32'd2 << FRAC);
    end
    return {hi, lo};
  endfunction

  initial begin
    tps_pkg::vertex_t v;
    int phase;
    board = new();
    error_count = 0;
    idle_cycles = 0;
    triangles_seen = 0;
    faults_seen = 0;
    rst <= 1'b1;
    start <= 1'b0;
    vert <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset identity matrix: w is exactly one, so no
    // divide happens; zeros give a degenerate triangle with a zero
    // determinant, and the field extremes exercise wrapping.
    send_vertex('0, 0);
    send_vertex('0, 0);
    send_vertex('0, 0);
    send_vertex(make_vertex(2), 0);
    send_vertex(make_vertex(3), 0);
    v.vert_x = 32'sd1 << FRAC; v.vert_y = 0; v.vert_z = 0;
    send_vertex(v, 0);
    send_vertex('0, 0);
    v.vert_x = 0; v.vert_y = 32'sd1 << FRAC;
    send_vertex(v, 0);
    v.vert_x = 32'sd2 << FRAC; v.vert_y = 0;
    send_vertex(v, 0);
    wait_drained();

    // Perspective case: w takes z, so a zero z is a zero divisor and
    // tiny z values saturate the quotient.
    write_matrix(7, 64'd65536);
    write_matrix(5, {32'd65536, 32'd65536});
    v = '0;
    send_vertex(v, 0);
    v.vert_x = 32'sd5 << FRAC; v.vert_y = -(32'sd3 << FRAC); v.vert_z = 32'sd1;
    send_vertex(v, 0);
    v.vert_x = -(32'sd5 << FRAC); v.vert_z = -32'sd1;
    send_vertex(v, 0);
    v.vert_x = 32'sd3 << FRAC; v.vert_y = 32'sd1 << FRAC; v.vert_z = 32'sd2 << FRAC;
    send_vertex(v, 0);
    send_vertex(make_vertex(2), 0);
    send_vertex(make_vertex(3), 0);
    wait_drained();

    // Random phases: each reprograms every register, one phase with all
    // ones and one with all zeros, then sends NUM_RANDOM/10 vertices, most with gaps.
    for (phase = 0; phase < 10; phase++) begin
      for (int i = 0; i < 8; i++) begin
        if (phase == 0) write_matrix(i, '1);
        else if (phase == 1) write_matrix(i, '0);
        else write_matrix(i, random_pair(phase % 4 == 3));
      end
      for (int n = 0; n < NUM_RANDOM / 10; n++) begin
        send_vertex(make_vertex($urandom_range(0, 9) < 7 ? 1 :
                                $urandom_range(0, 4)), $urandom_range(0, 3) != 0);
      end
      // In phase 4, let the sender hold off until every pending result is in.
      if (phase == 4) begin
        while (board.projected_q.size() != 0) @(posedge clk);
      end
      wait_drained();
    end

    $display("covered %0d triangles, %0d results with a divide fault, 12 matrix settings",
             triangles_seen, faults_seen);
    if (error_count == 0) begin
      $display("tb_triangle_projection_setup: done, clean");
    end else begin
      $display("tb_triangle_projection_setup: done, errors");
    end
    $finish;
  end

endmodule
